### sv/lzvl_pkg.sv
`timescale 1ns / 1ps

package lzvl_pkg;

  localparam int unsigned DIST_W    = 15;
  localparam int unsigned FAC_W     = 16;
  localparam int unsigned VEL_W     = 16;
  localparam int unsigned COORD_W   = 16;
  localparam int unsigned ZONES     = 4;
  localparam int unsigned DIV_STEPS = 15;
  localparam int unsigned DIV_CW    = $clog2(DIV_STEPS);
  localparam int unsigned Q_DEPTH   = 2;
  localparam int unsigned Q_AW      = $clog2(Q_DEPTH);
  localparam int unsigned Q_CW      = $clog2(Q_DEPTH + 1);
  localparam int unsigned IN_DW     = 80;
  localparam int unsigned OUT_DW    = 48;

  localparam logic [FAC_W-1:0]  FACTOR_ONE = 16'h8000;
  localparam logic [DIST_W-1:0] SLOW_RST   = 15'd1000;
  localparam logic [DIST_W-1:0] STOP_RST   = 15'd300;

  localparam logic CFG_SLOW = 1'b0;
  localparam logic CFG_STOP = 1'b1;

  localparam int unsigned Z_FRONT = 0;
  localparam int unsigned Z_REAR  = 1;
  localparam int unsigned Z_LEFT  = 2;
  localparam int unsigned Z_RIGHT = 3;

  typedef enum logic [1:0] {
    KIND_POINT = 2'd0,
    KIND_SCAN  = 2'd1,
    KIND_CMD   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_EXEC,
    BK_DIV,
    BK_MUL,
    BK_OUT
  } bk_state_t;

  typedef struct packed {
    kind_t                     kind;
    logic                      x_neg;
    logic                      y_neg;
    logic [COORD_W-1:0]        dx;
    logic [COORD_W-1:0]        dy;
    logic signed [VEL_W-1:0]   lin_x;
    logic signed [VEL_W-1:0]   lin_y;
    logic signed [VEL_W-1:0]   ang_z;
  } qent_t;

endpackage

### sv/lidar_zone_velocity_limiter.sv
`timescale 1ns / 1ps
// A command transfer passes the queue and the EXEC, MUL and OUT states before it
//   shows on out_tvalid; a point waits on the two 15-step serial ramp dividers.
//   The back end takes one item at a time; a 2-entry queue buffers the input.
// Reset (rst_n low, synchronous): queue emptied, zone flags cleared, factors set
//   to one, slow/stop distances back to 1000 / 300 mm.
module lidar_zone_velocity_limiter (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // point_x_mm, point_y_mm, cmd_lin_x, cmd_lin_y, cmd_ang_z
  input  logic [lzvl_pkg::IN_DW-1:0]      in_tdata,
  // kind
  input  logic [1:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // out_lin_x, out_lin_y, out_ang_z
  output logic [lzvl_pkg::OUT_DW-1:0]     out_tdata,
  input  logic                            cfg_we,
  input  logic                            cfg_idx,
  input  logic [lzvl_pkg::DIST_W-1:0]     cfg_wdata
);
  import lzvl_pkg::*;

  logic  q_full, q_empty, q_push, q_pop;
  qent_t q_wdata, q_rdata;

  lzvl_front u_front (
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .q_full(q_full), .q_push(q_push), .q_ent(q_wdata)
  );

  lzvl_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(q_push), .wdata(q_wdata), .full(q_full),
    .pop(q_pop), .rdata(q_rdata), .empty(q_empty)
  );

  lzvl_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata), .q_empty(q_empty), .q_ent(q_rdata), .q_pop(q_pop),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  a_ready_after_reset: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> in_tready)
    else $error("queue not empty after reset");

  a_queue_count: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_full && q_empty))
    else $error("queue full and empty at once");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("pop from empty queue");

endmodule

### sv/lzvl_front.sv
`timescale 1ns / 1ps

module lzvl_front (
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [lzvl_pkg::IN_DW-1:0] in_tdata,
  input  logic [1:0]              in_tuser,
  input  logic                    q_full,
  output logic                    q_push,
  output lzvl_pkg::qent_t         q_ent
);
  import lzvl_pkg::*;

  logic                      known;
  logic signed [COORD_W-1:0] px;
  logic signed [COORD_W-1:0] py;

  assign px = in_tdata[15:0];
  assign py = in_tdata[31:16];

  assign known = (in_tuser == KIND_POINT) || (in_tuser == KIND_SCAN) ||
                 (in_tuser == KIND_CMD);

  // reserved kind is taken and dropped
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full && known;

  always_comb begin
    q_ent.kind  = kind_t'(in_tuser);
    q_ent.x_neg = px[COORD_W-1];
    q_ent.y_neg = py[COORD_W-1];
    q_ent.dx    = px[COORD_W-1] ? COORD_W'(-px) : COORD_W'(px);
    q_ent.dy    = py[COORD_W-1] ? COORD_W'(-py) : COORD_W'(py);
    q_ent.lin_x = in_tdata[47:32];
    q_ent.lin_y = in_tdata[63:48];
    q_ent.ang_z = in_tdata[79:64];
  end

endmodule

### sv/lzvl_fifo.sv
`timescale 1ns / 1ps

module lzvl_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lzvl_pkg::qent_t wdata,
  output logic            full,
  input  logic            pop,
  output lzvl_pkg::qent_t rdata,
  output logic            empty
);
  import lzvl_pkg::*;

  qent_t           mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r;
  logic [Q_AW-1:0] rd_ptr_r;
  logic [Q_CW-1:0] cnt_r;
  logic [Q_AW-1:0] wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_nxt;
  logic [Q_CW-1:0] cnt_nxt;

  assign full  = (cnt_r == Q_CW'(Q_DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

### sv/lzvl_div.sv
`timescale 1ns / 1ps

// restoring divider: q = floor(num * 2^15 / den), needs num < den
module lzvl_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [lzvl_pkg::DIST_W-1:0] num,
  input  logic [lzvl_pkg::DIST_W-1:0] den,
  output logic                        done,
  output logic [lzvl_pkg::DIST_W-1:0] quo
);
  import lzvl_pkg::*;

  logic [DIST_W-1:0] rem_r;
  logic [DIST_W-1:0] den_r;
  logic [DIST_W-1:0] quo_r;
  logic [DIV_CW-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIST_W:0]   rem2;
  logic              ge;
  logic [DIST_W:0]   diff;

  assign rem2 = {rem_r, 1'b0};
  assign ge   = (rem2 >= {1'b0, den_r});
  assign diff = rem2 - {1'b0, den_r};
  assign done = done_r;
  assign quo  = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CW'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      den_r <= den;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DIST_W-1:0] : rem2[DIST_W-1:0];
      quo_r <= {quo_r[DIST_W-2:0], ge};
    end
  end

endmodule

### sv/lzvl_back.sv
`timescale 1ns / 1ps

module lzvl_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic                         cfg_idx,
  input  logic [lzvl_pkg::DIST_W-1:0]  cfg_wdata,
  input  logic                         q_empty,
  input  lzvl_pkg::qent_t              q_ent,
  output logic                         q_pop,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [lzvl_pkg::OUT_DW-1:0]  out_tdata
);
  import lzvl_pkg::*;

  function automatic logic signed [VEL_W-1:0] trunc_q15(input logic signed [32:0] p);
    logic signed [32:0] adj;
    adj = p + (p[32] ? 33'sd32767 : 33'sd0);
    return adj[30:15];
  endfunction

  bk_state_t state_r, state_nxt;

  logic [DIST_W-1:0] slow_r, stop_r;
  logic [ZONES-1:0]  live_flags_r, scan_flags_r;
  logic [FAC_W-1:0]  live_fac_r [ZONES];
  logic [FAC_W-1:0]  scan_fac_r [ZONES];
  logic [ZONES-1:0]  live_flags_nxt;
  logic [FAC_W-1:0]  live_fac_nxt [ZONES];
  qent_t             item_r;

  logic [FAC_W-1:0]   fx_r, fy_r, fa_r;
  logic [FAC_W-1:0]   fx_nxt, fy_nxt, fa_nxt;
  logic signed [32:0] px_r, py_r, pa_r;
  logic               out_tvalid_r;
  logic [OUT_DW-1:0]  out_tdata_r;

  logic div_start, commit, sel_en, upd, mul_en, out_load;
  logic done_x, done_y;
  logic [DIST_W-1:0] quo_x, quo_y;
  logic [DIST_W-1:0] num_x, num_y, den;
  logic hit_x, hit_y;
  logic [FAC_W-1:0] fac_x, fac_y;

  assign den   = slow_r - stop_r;
  assign num_x = item_r.dx[DIST_W-1:0] - stop_r;
  assign num_y = item_r.dy[DIST_W-1:0] - stop_r;

  lzvl_div u_div_x (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num(num_x), .den(den), .done(done_x), .quo(quo_x)
  );

  lzvl_div u_div_y (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num(num_y), .den(den), .done(done_y), .quo(quo_y)
  );

  assign hit_x = (item_r.dx <= {1'b0, slow_r});
  assign hit_y = (item_r.dy <= {1'b0, slow_r});

  always_comb begin
    if (item_r.dx <= {1'b0, stop_r}) begin
      fac_x = '0;
    end else if (item_r.dx >= {1'b0, slow_r}) begin
      fac_x = FACTOR_ONE;
    end else begin
      fac_x = {1'b0, quo_x};
    end
    if (item_r.dy <= {1'b0, stop_r}) begin
      fac_y = '0;
    end else if (item_r.dy >= {1'b0, slow_r}) begin
      fac_y = FACTOR_ONE;
    end else begin
      fac_y = {1'b0, quo_y};
    end
  end

  // zone accumulate after a point
  always_comb begin
    live_flags_nxt = live_flags_r;
    for (int z = 0; z < ZONES; z++) begin
      live_fac_nxt[z] = live_fac_r[z];
    end
    if (hit_x) begin
      if (item_r.x_neg) begin
        live_flags_nxt[Z_REAR] = 1'b1;
        if (fac_x < live_fac_r[Z_REAR]) live_fac_nxt[Z_REAR] = fac_x;
      end else begin
        live_flags_nxt[Z_FRONT] = 1'b1;
        if (fac_x < live_fac_r[Z_FRONT]) live_fac_nxt[Z_FRONT] = fac_x;
      end
    end
    if (hit_y) begin
      if (item_r.y_neg) begin
        live_flags_nxt[Z_RIGHT] = 1'b1;
        if (fac_y < live_fac_r[Z_RIGHT]) live_fac_nxt[Z_RIGHT] = fac_y;
      end else begin
        live_flags_nxt[Z_LEFT] = 1'b1;
        if (fac_y < live_fac_r[Z_LEFT]) live_fac_nxt[Z_LEFT] = fac_y;
      end
    end
  end

  // factor selection for a command
  always_comb begin
    if (item_r.lin_x[VEL_W-1]) begin
      fx_nxt = scan_flags_r[Z_REAR] ? scan_fac_r[Z_REAR] : FACTOR_ONE;
    end else begin
      fx_nxt = scan_flags_r[Z_FRONT] ? scan_fac_r[Z_FRONT] : FACTOR_ONE;
    end
    if (item_r.lin_y[VEL_W-1]) begin
      fy_nxt = scan_flags_r[Z_RIGHT] ? scan_fac_r[Z_RIGHT] : FACTOR_ONE;
    end else begin
      fy_nxt = scan_flags_r[Z_LEFT] ? scan_fac_r[Z_LEFT] : FACTOR_ONE;
    end
    fa_nxt = FACTOR_ONE;
    for (int z = 0; z < ZONES; z++) begin
      if (scan_flags_r[z] && (scan_fac_r[z] < fa_nxt)) begin
        fa_nxt = scan_fac_r[z];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) state_nxt = BK_EXEC;
      end
      BK_EXEC: begin
        unique case (item_r.kind)
          KIND_POINT: state_nxt = BK_DIV;
          KIND_CMD:   state_nxt = BK_MUL;
          default:    state_nxt = BK_IDLE;
        endcase
      end
      BK_DIV: begin
        if (done_x && done_y) state_nxt = BK_IDLE;
      end
      BK_MUL: state_nxt = BK_OUT;
      BK_OUT: begin
        if (!out_tvalid_r || out_tready) state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    div_start = 1'b0;
    commit    = 1'b0;
    sel_en    = 1'b0;
    upd       = 1'b0;
    mul_en    = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      BK_IDLE: q_pop = !q_empty;
      BK_EXEC: begin
        div_start = (item_r.kind == KIND_POINT);
        commit    = (item_r.kind == KIND_SCAN);
        sel_en    = (item_r.kind == KIND_CMD);
      end
      BK_DIV:  upd      = done_x && done_y;
      BK_MUL:  mul_en   = 1'b1;
      BK_OUT:  out_load = !out_tvalid_r || out_tready;
      default: q_pop    = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_IDLE;
      slow_r       <= SLOW_RST;
      stop_r       <= STOP_RST;
      live_flags_r <= '0;
      scan_flags_r <= '0;
      out_tvalid_r <= 1'b0;
      for (int z = 0; z < ZONES; z++) begin
        live_fac_r[z] <= FACTOR_ONE;
        scan_fac_r[z] <= FACTOR_ONE;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        if (cfg_idx == CFG_SLOW) slow_r <= cfg_wdata;
        if (cfg_idx == CFG_STOP) stop_r <= cfg_wdata;
      end
      if (upd) begin
        live_flags_r <= live_flags_nxt;
        for (int z = 0; z < ZONES; z++) begin
          live_fac_r[z] <= live_fac_nxt[z];
        end
      end else if (commit) begin
        scan_flags_r <= live_flags_r;
        live_flags_r <= '0;
        for (int z = 0; z < ZONES; z++) begin
          scan_fac_r[z] <= live_fac_r[z];
          live_fac_r[z] <= FACTOR_ONE;
        end
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) item_r <= q_ent;
    if (sel_en) begin
      fx_r <= fx_nxt;
      fy_r <= fy_nxt;
      fa_r <= fa_nxt;
    end
    if (mul_en) begin
      px_r <= item_r.lin_x * $signed({1'b0, fx_r});
      py_r <= item_r.lin_y * $signed({1'b0, fy_r});
      pa_r <= item_r.ang_z * $signed({1'b0, fa_r});
    end
    if (out_load) begin
      out_tdata_r <= {trunc_q15(pa_r), trunc_q15(py_r), trunc_q15(px_r)};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import lzvl_pkg::*;

  localparam logic [1:0] KIND_UNUSED   = 2'd3;
  localparam int         CYCLE_LIMIT   = 1_000_000;
  localparam int         SETTLE_CYCLES = 80;

  typedef struct {
    logic signed [VEL_W-1:0] lin_x;
    logic signed [VEL_W-1:0] lin_y;
    logic signed [VEL_W-1:0] ang_z;
  } vel_t;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  // point_x_mm, point_y_mm, cmd_lin_x, cmd_lin_y, cmd_ang_z
  logic [IN_DW-1:0]    in_tdata   = '0;
  // kind
  logic [1:0]          in_tuser   = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  // out_lin_x, out_lin_y, out_ang_z
  logic [OUT_DW-1:0]   out_tdata;
  logic                cfg_we     = 1'b0;
  logic                cfg_idx    = 1'b0;
  logic [DIST_W-1:0]   cfg_wdata  = '0;

  logic [DIST_W-1:0] slow_mm;
  logic [DIST_W-1:0] stop_mm;
  logic [ZONES-1:0]  live_flags;
  logic [ZONES-1:0]  scan_flags;
  logic [FAC_W-1:0]  live_fac [ZONES];
  logic [FAC_W-1:0]  scan_fac [ZONES];
  vel_t              limited_vel_q [$];

  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int hold_cycles   = 0;
  int err_count     = 0;
  int cycle_count   = 0;

  lidar_zone_velocity_limiter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------- zone predictor ----------------

  function automatic void clear_live();
    live_flags = '0;
    foreach (live_fac[i]) live_fac[i] = FACTOR_ONE;
  endfunction

  function automatic logic [COORD_W:0] magnitude(input logic signed [COORD_W-1:0] v);
    int vi = int'(v);
    return (COORD_W+1)'(vi < 0 ? -vi : vi);
  endfunction

  function automatic logic [FAC_W-1:0] ramp_factor(input logic [COORD_W:0] d);
    if (d <= stop_mm) return '0;
    if (d >= slow_mm) return FACTOR_ONE;
    return FAC_W'((longint'(d - stop_mm) * longint'(FACTOR_ONE)) /
                  longint'(slow_mm - stop_mm));
  endfunction

  function automatic void zone_hit(input int z, input logic [COORD_W:0] d);
    logic [FAC_W-1:0] f;
    if (d > slow_mm) return;
    live_flags[z] = 1'b1;
    f = ramp_factor(d);
    if (f < live_fac[z]) live_fac[z] = f;
  endfunction

  function automatic logic signed [VEL_W-1:0] scale_vel(input logic signed [VEL_W-1:0] v,
                                                         input logic [FAC_W-1:0] f);
    longint p = longint'(v) * longint'(f);
    return VEL_W'(p / longint'(FACTOR_ONE));
  endfunction

  function automatic void predict_limits(input logic [1:0] kind, input logic [IN_DW-1:0] data);
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic [FAC_W-1:0]          fa;
    vel_t                      v;
    px = data[COORD_W-1:0];
    py = data[2*COORD_W-1:COORD_W];
    case (kind)
      KIND_POINT: begin
        if (px >= 0) zone_hit(Z_FRONT, magnitude(px));
        else zone_hit(Z_REAR, magnitude(px));
        if (py >= 0) zone_hit(Z_LEFT, magnitude(py));
        else zone_hit(Z_RIGHT, magnitude(py));
      end
      KIND_SCAN: begin
        scan_flags = live_flags;
        scan_fac = live_fac;
        clear_live();
      end
      KIND_CMD: begin
        v.lin_x = data[2*COORD_W +: VEL_W];
        v.lin_y = data[2*COORD_W+VEL_W +: VEL_W];
        v.ang_z = data[2*COORD_W+2*VEL_W +: VEL_W];
        if (v.lin_x >= 0) begin
          if (scan_flags[Z_FRONT]) v.lin_x = scale_vel(v.lin_x, scan_fac[Z_FRONT]);
        end else begin
          if (scan_flags[Z_REAR]) v.lin_x = scale_vel(v.lin_x, scan_fac[Z_REAR]);
        end
        if (v.lin_y >= 0) begin
          if (scan_flags[Z_LEFT]) v.lin_y = scale_vel(v.lin_y, scan_fac[Z_LEFT]);
        end else begin
          if (scan_flags[Z_RIGHT]) v.lin_y = scale_vel(v.lin_y, scan_fac[Z_RIGHT]);
        end
        fa = FACTOR_ONE;
        for (int i = 0; i < ZONES; i++)
          if (scan_flags[i] && scan_fac[i] < fa) fa = scan_fac[i];
        v.ang_z = scale_vel(v.ang_z, fa);
        limited_vel_q = {limited_vel_q, v};
      end
      default: ;
    endcase
  endfunction

  // ---------------- checking ----------------

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  always @(posedge clk) begin : check_results
    vel_t                    want;
    logic signed [VEL_W-1:0] got_x;
    logic signed [VEL_W-1:0] got_y;
    logic signed [VEL_W-1:0] got_z;
    if (rst_n && out_tvalid && out_tready) begin
      got_x = out_tdata[VEL_W-1:0];
      got_y = out_tdata[2*VEL_W-1:VEL_W];
      got_z = out_tdata[3*VEL_W-1:2*VEL_W];
      if (limited_vel_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d %0d %0d", got_x, got_y, got_z));
      end else begin
        want = limited_vel_q.pop_front();
        if (got_x !== want.lin_x)
          report_mismatch($sformatf("out_lin_x got %0d want %0d", got_x, want.lin_x));
        if (got_y !== want.lin_y)
          report_mismatch($sformatf("out_lin_y got %0d want %0d", got_y, want.lin_y));
        if (got_z !== want.ang_z)
          report_mismatch($sformatf("out_ang_z got %0d want %0d", got_z, want.ang_z));
      end
    end
  end

  // receiver: random stalls plus an optional long hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // ---------------- stimulus ----------------

  task automatic send_item(input logic [1:0] kind, input logic [IN_DW-1:0] data);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    predict_limits(kind, data);
  endtask

  task automatic send_point(input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y);
    logic [IN_DW-1:0] d = IN_DW'({$urandom(), $urandom(), $urandom()});
    d[2*COORD_W-1:0] = {y, x};
    send_item(KIND_POINT, d);
  endtask

  task automatic send_scan_end();
    send_item(KIND_SCAN, IN_DW'({$urandom(), $urandom(), $urandom()}));
  endtask

  task automatic send_cmd(input logic signed [VEL_W-1:0] lx,
                          input logic signed [VEL_W-1:0] ly,
                          input logic signed [VEL_W-1:0] az);
    logic [IN_DW-1:0] d = IN_DW'({$urandom(), $urandom(), $urandom()});
    d[2*COORD_W +: 3*VEL_W] = {az, ly, lx};
    send_item(KIND_CMD, d);
  endtask

  // stop offering, wait for every pending result, then let queued points finish
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (limited_vel_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [DIST_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SLOW) slow_mm = value;
    else stop_mm = value;
  endtask

  task automatic set_distances(input int slow, input int stop);
    drain();
    cfg_write(CFG_SLOW, DIST_W'(slow));
    cfg_write(CFG_STOP, DIST_W'(stop));
  endtask

  function automatic logic signed [COORD_W-1:0] rand_coord();
    int span = int'(slow_mm) + int'(slow_mm) / 4 + 4;
    int v;
    case ($urandom_range(9))
      0: return COORD_W'($urandom());
      1: v = int'(stop_mm) + $urandom_range(1);
      2: v = int'(slow_mm) + $urandom_range(1);
      default: v = $urandom_range(span);
    endcase
    if (v > 32767) v = 32767;
    return COORD_W'($urandom_range(1) ? -v : v);
  endfunction

  function automatic logic signed [VEL_W-1:0] rand_vel();
    case ($urandom_range(19))
      0: return '0;
      1: return 16'sh7fff;
      2: return 16'sh8000;
      3: return -16'sd1;
      default: return VEL_W'($urandom());
    endcase
  endfunction

  task automatic pick_distances();
    int s;
    case ($urandom_range(5))
      0: set_distances(32767, 0);
      1: begin
        s = $urandom_range(2000);
        set_distances(s, $urandom_range(2500, s));
      end
      default: begin
        s = $urandom_range(4000, 1);
        set_distances(s, $urandom_range(s - 1));
      end
    endcase
  endtask

  // ---------------- tests ----------------

  task automatic test_directed_cases();
    send_cmd(16'sd1000, -16'sd1000, 16'sd500);
    send_point(16'sd650, -16'sd650);
    send_point(16'sd1000, 16'sd999);
    send_point(16'sh8000, 16'sh8000);
    send_point(16'sh7fff, 16'sh7fff);
    send_point(-16'sd1001, 16'sd1001);
    send_item(KIND_UNUSED, IN_DW'({$urandom(), $urandom(), $urandom()}));
    send_scan_end();
    send_cmd(16'sh7fff, 16'sh8000, 16'sh8000);
    send_cmd(16'sh8000, 16'sh7fff, 16'sh7fff);
    send_cmd(16'sd0, 16'sd0, 16'sd0);
    send_cmd(-16'sd1, -16'sd1, -16'sd1);
    send_point(16'sd0, 16'sd0);
    send_point(-16'sd1, -16'sd1);
    send_point(16'sd300, -16'sd301);
    send_scan_end();
    send_cmd(16'sd1234, -16'sd1234, 16'sh8000);
    send_scan_end();
    send_cmd(16'sh8000, 16'sh8000, 16'sh8000);
    drain();
  endtask

  task automatic test_distance_extremes();
    int slow_set [6] = '{32767, 0, 500, 700, 32767, 1};
    int stop_set [6] = '{0,     0, 800, 700, 32767, 0};
    int s;
    int p;
    foreach (slow_set[i]) begin
      set_distances(slow_set[i], stop_set[i]);
      s = slow_set[i];
      p = stop_set[i];
      send_point(16'sd0, -16'sd1);
      send_point(COORD_W'(p), COORD_W'(-(p + 1)));
      send_point(COORD_W'(-s), COORD_W'(s));
      send_point(COORD_W'(s + 1), COORD_W'(-(s + 1)));
      send_point(COORD_W'(-((s + p) / 2)), COORD_W'((s + p) / 2 + 1));
      send_scan_end();
      send_cmd(16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_cmd(16'sh8000, 16'sh8000, 16'sh8000);
      send_cmd(-16'sd5, 16'sd7, -16'sd9);
    end
    drain();
  endtask

  task automatic run_random_scans(input int n_items);
    int               sent = 0;
    int               npts;
    int               ncmd;
    logic [1:0]       kind;
    logic [IN_DW-1:0] d;
    while (sent < n_items) begin
      if ($urandom_range(99) < 85) begin
        npts = $urandom_range(10);
        repeat (npts) send_point(rand_coord(), rand_coord());
        send_scan_end();
        ncmd = $urandom_range(3, 1);
        repeat (ncmd) send_cmd(rand_vel(), rand_vel(), rand_vel());
        sent += npts + 1 + ncmd;
      end else begin
        kind = 2'($urandom_range(3));
        d = IN_DW'({$urandom(), $urandom(), $urandom()});
        send_item(kind, d);
        if (kind != KIND_UNUSED) sent++;
      end
    end
  endtask

  task automatic test_random_traffic();
    int src_set  [3] = '{25, 85, 0};
    int sink_set [3] = '{85, 25, 0};
    foreach (src_set[m]) begin
      src_idle_pct  = src_set[m];
      sink_idle_pct = sink_set[m];
      repeat (3) begin
        pick_distances();
        run_random_scans(167);
      end
    end
    drain();
  endtask

  // receiver stalls long enough for the input queue to fill and back up
  task automatic test_output_holdoff();
    set_distances(1000, 200);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    hold_cycles <= 400;
    send_point(16'sd500, -16'sd900);
    send_point(-16'sd250, 16'sd700);
    send_scan_end();
    repeat (16) send_cmd(rand_vel(), rand_vel(), rand_vel());
    drain();
  endtask

  initial begin
    slow_mm = SLOW_RST;
    stop_mm = STOP_RST;
    clear_live();
    scan_flags = '0;
    foreach (scan_fac[i]) scan_fac[i] = FACTOR_ONE;
    src_idle_pct  = 25;
    sink_idle_pct = 85;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_distance_extremes();
    test_random_traffic();
    test_output_holdoff();

    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
